[design/mono_framebuffer_rect_fill_page_pack_top_defines.svh]
// Assertion macros used by the framebuffer top level.
`ifndef MONO_FRAMEBUFFER_RECT_FILL_PAGE_PACK_TOP_DEFINES_SVH
`define MONO_FRAMEBUFFER_RECT_FILL_PAGE_PACK_TOP_DEFINES_SVH

// Checks a property on every clock edge outside reset.
`define MFBPP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks a property on every clock edge, reset cycles included.
`define MFBPP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[design/mfbpp_pkg.sv]
// Package with the command codes and the input transaction type of the framebuffer.
package mfbpp_pkg;

  localparam int OPCODE_W      = 2;
  localparam int X_W           = 7;
  localparam int Y_W           = 5;
  localparam int PAGE_W        = 2;
  localparam int BYTE_W        = 8;
  localparam int ROWS_PER_PAGE = 8;

  typedef enum logic [OPCODE_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_FILL  = 2'd1,
    OP_READ  = 2'd2
  } opcode_t;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [X_W-1:0]      rect_x;
    logic [Y_W-1:0]      rect_y;
    logic [X_W-1:0]      rect_width;
    logic [Y_W-1:0]      rect_height;
    logic [PAGE_W-1:0]   read_page;
    logic [X_W-1:0]      read_column;
  } item_t;

endpackage

[design/mono_framebuffer_rect_fill_page_pack_top.sv]
// Top level of the one-bit page framebuffer with rectangle fill.
//
//  Channel  Direction  Handshake              Payload
//  in_      input      in_valid / in_ready    opcode, rect_x/y/width/height, read_page/column
//  out_     output     out_valid / out_ready  page_byte (one per read transaction)
//
// The pixels live in one memory of SCREEN_WIDTH column words, SCREEN_HEIGHT bits each.
// A fill transaction does one read-modify-write per column through the single read and
// single write port, and then the trailing write of the last column in S_DRAIN.
// A clear transaction sweeps all SCREEN_WIDTH words, one per cycle; the same sweep runs
// after reset, so in_ready stays low until that sweep is done.
// A read passes through S_RD_ISSUE and S_RD_WAIT and leaves S_RD_WAIT once the output register takes its byte;
// a held byte lets fills and clears go on, but a second read then stalls in_ready until out_ready drains the first.
`include "mono_framebuffer_rect_fill_page_pack_top_defines.svh"

module mono_framebuffer_rect_fill_page_pack_top #(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_opcode,
  input  logic [6:0] in_rect_x,
  input  logic [4:0] in_rect_y,
  input  logic [6:0] in_rect_width,
  input  logic [4:0] in_rect_height,
  input  logic [1:0] in_read_page,
  input  logic [6:0] in_read_column,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_page_byte
);

  import mfbpp_pkg::*;

  localparam int AW = $clog2(SCREEN_WIDTH);

  item_t                    item;
  logic                     res_valid, res_ready;
  logic [BYTE_W-1:0]        res_byte;
  logic                     mem_we, mem_re;
  logic [AW-1:0]            mem_waddr, mem_raddr;
  logic [SCREEN_HEIGHT-1:0] mem_wdata, mem_rdata;
  logic                     out_valid_r;
  logic [BYTE_W-1:0]        out_page_byte_r;

  assign item = '{
    opcode:      in_opcode,
    rect_x:      in_rect_x,
    rect_y:      in_rect_y,
    rect_width:  in_rect_width,
    rect_height: in_rect_height,
    read_page:   in_read_page,
    read_column: in_read_column
  };

  mfbpp_mem #(
    .DEPTH (SCREEN_WIDTH),
    .WIDTH (SCREEN_HEIGHT)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  mfbpp_seq #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .item      (item),
    .res_valid (res_valid),
    .res_byte  (res_byte),
    .res_ready (res_ready),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // Output register: it takes a new byte whenever it is empty or being drained.
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (res_valid && res_ready) begin
      out_page_byte_r <= res_byte;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_page_byte = out_page_byte_r;

  // The clearing sweep always follows reset, so no transaction is taken right after it.
  `MFBPP_ASSERT_ALWAYS(a_clear_after_reset, !rst_n |=> !in_ready, "transaction taken during reset sweep")

  // A read transaction reaches the output register path by way of S_RD_ISSUE and S_RD_WAIT after acceptance.
  `MFBPP_ASSERT(a_read_latency, in_valid && in_ready && in_opcode == OP_READ |=> ##1 res_valid, "read result late")

  // A byte held back by a full output register stays put until taken.
  `MFBPP_ASSERT(a_result_held, res_valid && !res_ready |=> res_valid && $stable(res_byte), "stalled read byte changed")

endmodule

[design/mfbpp_mem.sv]
// Column word memory: one write port, one read port with registered read data.
module mfbpp_mem #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] ram_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      ram_r[waddr] <= wdata;
    end
  end

  // Read data only changes on a read, so it holds while a result is stalled.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= ram_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[design/mfbpp_seq.sv]
// Command sequencer: clearing sweep, read-modify-write fill and page byte read.
module mfbpp_seq #(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  mfbpp_pkg::item_t                item,
  output logic                            res_valid,
  output logic [mfbpp_pkg::BYTE_W-1:0]    res_byte,
  input  logic                            res_ready,
  output logic                            mem_we,
  output logic [$clog2(SCREEN_WIDTH)-1:0] mem_waddr,
  output logic [SCREEN_HEIGHT-1:0]        mem_wdata,
  output logic                            mem_re,
  output logic [$clog2(SCREEN_WIDTH)-1:0] mem_raddr,
  input  logic [SCREEN_HEIGHT-1:0]        mem_rdata
);

  import mfbpp_pkg::*;

  localparam int AW     = $clog2(SCREEN_WIDTH);
  localparam int XS_W   = ((AW > X_W) ? AW : X_W) + 1;
  localparam int YS_W   = (($clog2(SCREEN_HEIGHT) > Y_W) ? $clog2(SCREEN_HEIGHT) : Y_W) + 1;
  localparam int FIRST_W = PAGE_W + $clog2(ROWS_PER_PAGE);
  localparam int PAD_W  = SCREEN_HEIGHT + (1 << FIRST_W);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_FILL,
    S_DRAIN,
    S_RD_ISSUE,
    S_RD_WAIT
  } state_t;

  state_t                   state_r, state_nxt;
  logic [AW-1:0]            col_r, col_nxt;
  logic [AW-1:0]            last_r, last_nxt;
  logic [SCREEN_HEIGHT-1:0] mask_r, mask_nxt;
  logic                     wb_valid_r, wb_valid_nxt;
  logic [AW-1:0]            wb_addr_r, wb_addr_nxt;
  logic                     rd_zero_r, rd_zero_nxt;
  logic [FIRST_W-1:0]       rd_first_r, rd_first_nxt;

  logic [XS_W-1:0]          x_ext, x_sum, x_last, col_ext;
  logic                     x_out, rd_out;
  logic [YS_W-1:0]          y_ext, y_sum, y_last;
  logic                     y_out;
  logic [SCREEN_HEIGHT-1:0] row_mask;
  logic [PAD_W-1:0]         rd_pad, rd_shift;

  // Clip the rectangle against the screen edges, build its row mask and range-check the read column.
  always_comb begin
    x_ext   = XS_W'(item.rect_x);
    x_sum   = x_ext + XS_W'(item.rect_width);
    x_out   = x_ext >= XS_W'(SCREEN_WIDTH);
    x_last  = (x_sum > XS_W'(SCREEN_WIDTH - 1)) ? XS_W'(SCREEN_WIDTH - 1) : x_sum;
    y_ext   = YS_W'(item.rect_y);
    y_sum   = y_ext + YS_W'(item.rect_height);
    y_out   = y_ext >= YS_W'(SCREEN_HEIGHT);
    y_last  = (y_sum > YS_W'(SCREEN_HEIGHT - 1)) ? YS_W'(SCREEN_HEIGHT - 1) : y_sum;
    col_ext = XS_W'(item.read_column);
    rd_out  = col_ext >= XS_W'(SCREEN_WIDTH);
    for (int i = 0; i < SCREEN_HEIGHT; i++) begin
      row_mask[i] = (YS_W'(i) >= y_ext) && (YS_W'(i) <= y_last);
    end
  end

  always_comb begin
    state_nxt    = state_r;
    col_nxt      = col_r;
    last_nxt     = last_r;
    mask_nxt     = mask_r;
    rd_zero_nxt  = rd_zero_r;
    rd_first_nxt = rd_first_r;
    wb_valid_nxt = (state_r == S_FILL);
    wb_addr_nxt  = col_r;
    unique case (state_r)
      S_CLEAR: begin
        if (col_r == AW'(SCREEN_WIDTH - 1)) begin
          state_nxt = S_IDLE;
          col_nxt   = '0;
        end else begin
          col_nxt = col_r + AW'(1);
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          unique case (item.opcode)
            OP_CLEAR: begin
              state_nxt = S_CLEAR;
              col_nxt   = '0;
            end
            OP_FILL: begin
              if (!x_out && !y_out) begin
                state_nxt = S_FILL;
                col_nxt   = x_ext[AW-1:0];
                last_nxt  = x_last[AW-1:0];
                mask_nxt  = row_mask;
              end
            end
            OP_READ: begin
              state_nxt    = S_RD_ISSUE;
              col_nxt      = col_ext[AW-1:0];
              rd_zero_nxt  = rd_out;
              rd_first_nxt = {item.read_page, {$clog2(ROWS_PER_PAGE){1'b0}}};
            end
            default: begin
            end
          endcase
        end
      end
      S_FILL: begin
        if (col_r == last_r) begin
          state_nxt = S_DRAIN;
        end else begin
          col_nxt = col_r + AW'(1);
        end
      end
      S_DRAIN: begin
        state_nxt = S_IDLE;
      end
      S_RD_ISSUE: begin
        state_nxt = S_RD_WAIT;
      end
      S_RD_WAIT: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      col_r      <= '0;
      wb_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      col_r      <= col_nxt;
      wb_valid_r <= wb_valid_nxt;
    end
    last_r     <= last_nxt;
    mask_r     <= mask_nxt;
    wb_addr_r  <= wb_addr_nxt;
    rd_zero_r  <= rd_zero_nxt;
    rd_first_r <= rd_first_nxt;
  end

  // The write stage runs in the cycle after the read, always on the column read just before.
  assign mem_re    = (state_r == S_FILL) || (state_r == S_RD_ISSUE);
  assign mem_raddr = col_r;
  assign mem_we    = (state_r == S_CLEAR) || wb_valid_r;
  assign mem_waddr = (state_r == S_CLEAR) ? col_r : wb_addr_r;
  assign mem_wdata = (state_r == S_CLEAR) ? '0 : (mem_rdata | mask_r);

  // Rows past the bottom edge shift in as zero bits.
  always_comb begin
    rd_pad   = {{(PAD_W - SCREEN_HEIGHT){1'b0}}, mem_rdata};
    rd_shift = rd_pad >> rd_first_r;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_RD_WAIT);
  assign res_byte  = rd_zero_r ? '0 : rd_shift[BYTE_W-1:0];

endmodule
